### rtl/slx_pkg.sv
`default_nettype none
package slx_pkg;

	localparam int OFFSET_BITS = 24;
	localparam int LENGTH_BITS = 16;
	localparam int KIND_BITS = 6;
	localparam int KW_COUNT = 18;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = 2;

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

	localparam logic [KIND_BITS-1:0] K_STAR   = 6'd18;
	localparam logic [KIND_BITS-1:0] K_COMMA  = 6'd19;
	localparam logic [KIND_BITS-1:0] K_LPAREN = 6'd20;
	localparam logic [KIND_BITS-1:0] K_RPAREN = 6'd21;
	localparam logic [KIND_BITS-1:0] K_EQ     = 6'd22;
	localparam logic [KIND_BITS-1:0] K_GT     = 6'd23;
	localparam logic [KIND_BITS-1:0] K_LT     = 6'd24;
	localparam logic [KIND_BITS-1:0] K_GE     = 6'd25;
	localparam logic [KIND_BITS-1:0] K_LE     = 6'd26;
	localparam logic [KIND_BITS-1:0] K_NE     = 6'd27;
	localparam logic [KIND_BITS-1:0] K_IDENT  = 6'd28;
	localparam logic [KIND_BITS-1:0] K_INT    = 6'd29;
	localparam logic [KIND_BITS-1:0] K_STR    = 6'd30;
	localparam logic [KIND_BITS-1:0] K_END    = 6'd31;
	localparam logic [KIND_BITS-1:0] K_UNK    = 6'd32;

	// keyword text, first character in the top byte, zero padded
	localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
		"CREATE", {"TABLE", 8'h00}, {"INDEX", 8'h00}, {"ON", 32'h0},
		"INSERT", {"INTO", 16'h0}, "VALUES", "SELECT",
		"UPDATE", "DELETE", {"SET", 24'h0}, {"JOIN", 16'h0},
		{"FROM", 16'h0}, {"INT", 24'h0}, {"TEXT", 16'h0}, {"WHERE", 8'h00},
		{"AND", 24'h0}, {"OR", 32'h0}
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{
		3'd6, 3'd5, 3'd5, 3'd2, 3'd6, 3'd4, 3'd6, 3'd6, 3'd6,
		3'd6, 3'd3, 3'd4, 3'd4, 3'd3, 3'd4, 3'd5, 3'd3, 3'd2
	};

	typedef struct packed {
		logic [KIND_BITS-1:0]   kind;
		logic [OFFSET_BITS-1:0] offset;
		logic [LENGTH_BITS-1:0] size;
	} tok_t;

	// tokens caused by one character: t0 always, t1 when two is set
	typedef struct packed {
		tok_t t0;
		tok_t t1;
		logic two;
	} rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

### rtl/sql_token_lexer_top.sv
// Streaming SQL lexer, one character word per cycle while in_stall is low.
// Input channel: in_valid/in_stall with char_code and end_of_text. A word with
// end_of_text set flushes any pending token, emits an end token and restarts
// the character position at zero.
// Output channel: out_valid/out_stall with token_kind, token_offset,
// token_size and last_of_run; last_of_run marks the final token caused by one
// input word (a word can cause zero, one or two tokens).
// The first token of a word passes through the queue and then the output register
// to out_valid; a second token of the same word is presented once the first is taken.
// Throughput: one word per cycle while each word yields at most one token; the
// output register sends one token per cycle, so a two-token word needs a second
// output transfer. A four-entry queue between the lexing front end and the output
// stage absorbs that and any receiver stall; in_stall rises only when it is full.
// Reset: lexer idle, position zero, queue empty, out_valid low.
// While out_stall is high the presented token holds and the queue keeps filling.
`default_nettype none
module sql_token_lexer_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [7:0]                  char_code,
	input  wire logic                        end_of_text,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [slx_pkg::KIND_BITS-1:0]    token_kind,
	output logic [slx_pkg::OFFSET_BITS-1:0]  token_offset,
	output logic [slx_pkg::LENGTH_BITS-1:0]  token_size,
	output logic                             last_of_run
);
	import slx_pkg::*;

	logic    push, pop;
	rec_t    push_rec, head;
	q_stat_t q_stat;

	slx_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.end_of_text(end_of_text),
		.q_stat(q_stat),
		.push(push),
		.push_rec(push_rec)
	);

	slx_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_rec(push_rec),
		.pop(pop),
		.head(head),
		.q_stat(q_stat)
	);

	slx_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.q_stat(q_stat),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.token_kind(token_kind),
		.token_offset(token_offset),
		.token_size(token_size),
		.last_of_run(last_of_run)
	);

	// an end-of-text word always leaves a record in the queue
	a_eot_queued: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && end_of_text |=> !q_stat.empty)
		else $error("end-of-text word left no queued record");

	// the second token of a word follows right behind the first
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid)
		else $error("second token of a word did not follow");

	// never pop an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

endmodule
`default_nettype wire

### rtl/slx_front.sv
`default_nettype none
module slx_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         char_code,
	input  wire logic               end_of_text,
	input  wire slx_pkg::q_stat_t   q_stat,
	output logic                    push,
	output slx_pkg::rec_t           push_rec
);
	import slx_pkg::*;

	localparam logic [2:0] M_IDLE  = 3'd0;
	localparam logic [2:0] M_IDENT = 3'd1;
	localparam logic [2:0] M_NUM   = 3'd2;
	localparam logic [2:0] M_STR   = 3'd3;
	localparam logic [2:0] M_GT    = 3'd4;
	localparam logic [2:0] M_LT    = 3'd5;
	localparam logic [2:0] M_BANG  = 3'd6;

	logic [2:0]             mode_q, nxt_mode;
	logic [5:0][7:0]        win_q, nxt_win;
	logic [LENGTH_BITS-1:0] run_len_q, nxt_len, len_inc;
	logic [OFFSET_BITS-1:0] run_start_q, nxt_start, pos_q, nxt_pos;
	logic                   e0_v, s_v, consumed, take;
	tok_t                   e0, s, fl;
	logic [7:0]             up;
	logic                   c_alpha, c_digit, c_space, c_word;

	function automatic logic [KIND_BITS-1:0] kw_lookup(input logic [5:0][7:0] w,
			input logic [LENGTH_BITS-1:0] n);
		logic [KIND_BITS-1:0] r;
		logic                 hit;
		r = K_IDENT;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			hit = (n == LENGTH_BITS'(KW_LEN[k]));
			for (int i = 0; i < 6; i++) begin
				if (i < int'(KW_LEN[k]) && w[i] != KW_TEXT[k][47-8*i -: 8])
					hit = 1'b0;
			end
			if (hit)
				r = KIND_BITS'(k);
		end
		return r;
	endfunction

	assign c_alpha = (char_code >= "A" && char_code <= "Z") ||
		(char_code >= "a" && char_code <= "z");
	assign c_digit = char_code >= "0" && char_code <= "9";
	assign c_space = char_code == " " || (char_code >= 8'd9 && char_code <= 8'd13);
	assign c_word = c_alpha || c_digit || char_code == "_";
	assign up = (char_code >= "a" && char_code <= "z") ? char_code - 8'd32 : char_code;
	assign len_inc = (run_len_q == LEN_MAX) ? run_len_q : run_len_q + LENGTH_BITS'(1);

	// pending token as it stands if the run ends here
	always_comb begin
		fl.offset = run_start_q;
		fl.size = run_len_q;
		case (mode_q)
			M_IDENT: fl.kind = kw_lookup(win_q, run_len_q);
			M_NUM:   fl.kind = K_INT;
			M_GT: begin
				fl.kind = K_GT;
				fl.size = LENGTH_BITS'(1);
			end
			M_LT: begin
				fl.kind = K_LT;
				fl.size = LENGTH_BITS'(1);
			end
			M_BANG: begin
				fl.kind = K_UNK;
				fl.size = LENGTH_BITS'(1);
			end
			default: fl.kind = K_UNK;
		endcase
	end

	always_comb begin
		nxt_mode = mode_q;
		nxt_win = win_q;
		nxt_len = run_len_q;
		nxt_start = run_start_q;
		nxt_pos = pos_q + OFFSET_BITS'(1);
		e0_v = 1'b0;
		e0 = fl;
		s_v = 1'b0;
		s.kind = K_UNK;
		s.offset = pos_q;
		s.size = LENGTH_BITS'(1);
		consumed = 1'b0;
		if (end_of_text) begin
			e0_v = mode_q != M_IDLE;
			s_v = 1'b1;
			s.kind = K_END;
			s.size = '0;
			nxt_mode = M_IDLE;
			nxt_len = '0;
			nxt_pos = '0;
		end else begin
			case (mode_q)
				M_IDENT: begin
					if (c_word) begin
						if (run_len_q < LENGTH_BITS'(6))
							nxt_win[run_len_q[2:0]] = up;
						nxt_len = len_inc;
						consumed = 1'b1;
					end else begin
						e0_v = 1'b1;
					end
				end
				M_NUM: begin
					if (c_digit) begin
						nxt_len = len_inc;
						consumed = 1'b1;
					end else begin
						e0_v = 1'b1;
					end
				end
				M_STR: begin
					consumed = 1'b1;
					if (char_code == "'") begin
						e0_v = 1'b1;
						e0.kind = K_STR;
						nxt_mode = M_IDLE;
						nxt_len = '0;
					end else begin
						nxt_len = len_inc;
					end
				end
				M_GT, M_LT, M_BANG: begin
					e0_v = 1'b1;
					if (char_code == "=") begin
						consumed = 1'b1;
						e0.size = LENGTH_BITS'(2);
						e0.kind = (mode_q == M_GT) ? K_GE : ((mode_q == M_LT) ? K_LE : K_NE);
						nxt_mode = M_IDLE;
						nxt_len = '0;
					end
				end
				default: ;
			endcase
			if (!consumed) begin
				nxt_mode = M_IDLE;
				if (e0_v)
					nxt_len = '0;
				if (c_space) begin
				end else if (c_alpha || char_code == "_") begin
					nxt_mode = M_IDENT;
					nxt_start = pos_q;
					nxt_len = LENGTH_BITS'(1);
					nxt_win = '0;
					nxt_win[0] = up;
				end else if (c_digit) begin
					nxt_mode = M_NUM;
					nxt_start = pos_q;
					nxt_len = LENGTH_BITS'(1);
				end else begin
					case (char_code)
						"'": begin
							nxt_mode = M_STR;
							nxt_start = pos_q + OFFSET_BITS'(1);
							nxt_len = '0;
						end
						"*": begin
							s_v = 1'b1;
							s.kind = K_STAR;
						end
						",": begin
							s_v = 1'b1;
							s.kind = K_COMMA;
						end
						"(": begin
							s_v = 1'b1;
							s.kind = K_LPAREN;
						end
						")": begin
							s_v = 1'b1;
							s.kind = K_RPAREN;
						end
						"=": begin
							s_v = 1'b1;
							s.kind = K_EQ;
						end
						">": begin
							nxt_mode = M_GT;
							nxt_start = pos_q;
							nxt_len = LENGTH_BITS'(1);
						end
						"<": begin
							nxt_mode = M_LT;
							nxt_start = pos_q;
							nxt_len = LENGTH_BITS'(1);
						end
						"!": begin
							nxt_mode = M_BANG;
							nxt_start = pos_q;
							nxt_len = LENGTH_BITS'(1);
						end
						default: s_v = 1'b1;
					endcase
				end
			end
		end
	end

	assign in_stall = q_stat.full;
	assign take = in_valid && !q_stat.full;
	assign push = take && (e0_v || s_v);

	always_comb begin
		push_rec.t0 = e0_v ? e0 : s;
		push_rec.t1 = s;
		push_rec.two = e0_v && s_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			win_q <= '0;
			run_len_q <= '0;
			run_start_q <= '0;
			pos_q <= '0;
		end else if (take) begin
			mode_q <= nxt_mode;
			win_q <= nxt_win;
			run_len_q <= nxt_len;
			run_start_q <= nxt_start;
			pos_q <= nxt_pos;
		end
	end

endmodule
`default_nettype wire

### rtl/slx_queue.sv
`default_nettype none
module slx_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire slx_pkg::rec_t    push_rec,
	input  wire logic             pop,
	output slx_pkg::rec_t         head,
	output slx_pkg::q_stat_t      q_stat
);
	import slx_pkg::*;

	rec_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q, rd_q;
	logic [QUEUE_AW:0]   cnt_q;

	assign q_stat.full = cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign q_stat.empty = cnt_q == '0;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QUEUE_AW'(1);
			if (pop)
				rd_q <= rd_q + QUEUE_AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (QUEUE_AW+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (QUEUE_AW+1)'(1);
		end
	end

endmodule
`default_nettype wire

### rtl/slx_back.sv
`default_nettype none
module slx_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire slx_pkg::rec_t               head,
	input  wire slx_pkg::q_stat_t            q_stat,
	output logic                             pop,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [slx_pkg::KIND_BITS-1:0]    token_kind,
	output logic [slx_pkg::OFFSET_BITS-1:0]  token_offset,
	output logic [slx_pkg::LENGTH_BITS-1:0]  token_size,
	output logic                             last_of_run
);
	import slx_pkg::*;

	logic oval_q, phase_q, load, last;
	tok_t tok_q, pick;

	assign load = !oval_q || !out_stall;
	assign pick = phase_q ? head.t1 : head.t0;
	assign last = phase_q || !head.two;
	assign pop = load && !q_stat.empty && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			oval_q <= !q_stat.empty;
			if (!q_stat.empty)
				phase_q <= !last;
		end
	end

	// payload: hold while stalled
	always_ff @(posedge clk) begin
		if (load && !q_stat.empty) begin
			tok_q <= pick;
			last_of_run <= last;
		end
	end

	assign out_valid = oval_q;
	assign token_kind = tok_q.kind;
	assign token_offset = tok_q.offset;
	assign token_size = tok_q.size;

endmodule
`default_nettype wire

### tb/sv/lex_token_checker.sv
`timescale 1ns / 100ps
module lex_token_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic                            in_stall,
	input  wire logic [7:0]                      char_code,
	input  wire logic                            end_of_text,
	input  wire logic                            out_valid,
	input  wire logic                            out_stall,
	input  wire logic [slx_pkg::KIND_BITS-1:0]   token_kind,
	input  wire logic [slx_pkg::OFFSET_BITS-1:0] token_offset,
	input  wire logic [slx_pkg::LENGTH_BITS-1:0] token_size,
	input  wire logic                            last_of_run,
	output int                                   fail_count,
	output int                                   tokens_due
);
	import slx_pkg::*;

	typedef enum logic [2:0] {
		LX_IDLE, LX_IDENT, LX_NUM, LX_STR, LX_GT, LX_LT, LX_BANG
	} lex_mode_e;

	typedef struct packed {
		tok_t tok;
		logic last;
	} due_token_t;

	lex_mode_e              mode;
	logic [7:0]             kw_window [6];
	logic [LENGTH_BITS-1:0] run_len;
	logic [OFFSET_BITS-1:0] run_at;
	logic [OFFSET_BITS-1:0] char_pos;

	due_token_t due_tokens [$];
	tok_t       word_tokens [$];
	due_token_t exp_tok;

	function automatic logic is_letter(logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic [7:0] upcase(logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	// exact length and folded text must both match
	function automatic logic [KIND_BITS-1:0] word_kind();
		for (int k = 0; k < KW_COUNT; k++) begin
			if (run_len == LENGTH_BITS'(KW_LEN[k]) &&
					{kw_window[0], kw_window[1], kw_window[2], kw_window[3],
					kw_window[4], kw_window[5]} == KW_TEXT[k])
				return KIND_BITS'(k);
		end
		return K_IDENT;
	endfunction

	task automatic add_token(logic [KIND_BITS-1:0] kind, logic [OFFSET_BITS-1:0] at,
			logic [LENGTH_BITS-1:0] size);
		tok_t t;
		t.kind = kind;
		t.offset = at;
		t.size = size;
		if (word_tokens.size() < 2)
			word_tokens.push_back(t);
	endtask

	task automatic grow_run();
		if (run_len != LEN_MAX)
			run_len++;
	endtask

	task automatic flush_run();
		case (mode)
			LX_IDENT: add_token(word_kind(), run_at, run_len);
			LX_NUM:   add_token(K_INT, run_at, run_len);
			LX_STR:   add_token(K_UNK, run_at, run_len);
			LX_GT:    add_token(K_GT, run_at, 1);
			LX_LT:    add_token(K_LT, run_at, 1);
			LX_BANG:  add_token(K_UNK, run_at, 1);
			default: ;
		endcase
		mode = LX_IDLE;
		run_len = '0;
	endtask

	task automatic begin_char(logic [7:0] c, logic [OFFSET_BITS-1:0] p);
		if (is_blank(c))
			return;
		if (is_letter(c) || c == "_") begin
			mode = LX_IDENT;
			run_at = p;
			run_len = 1;
			foreach (kw_window[i])
				kw_window[i] = '0;
			kw_window[0] = upcase(c);
			return;
		end
		if (is_digit(c)) begin
			mode = LX_NUM;
			run_at = p;
			run_len = 1;
			return;
		end
		case (c)
			"'": begin
				mode = LX_STR;
				run_at = p + 1'b1;
				run_len = '0;
			end
			"*": add_token(K_STAR, p, 1);
			",": add_token(K_COMMA, p, 1);
			"(": add_token(K_LPAREN, p, 1);
			")": add_token(K_RPAREN, p, 1);
			"=": add_token(K_EQ, p, 1);
			">", "<", "!": begin
				mode = (c == ">") ? LX_GT : (c == "<") ? LX_LT : LX_BANG;
				run_at = p;
				run_len = 1;
			end
			default: add_token(K_UNK, p, 1);
		endcase
	endtask

	task automatic lex_word(logic [7:0] c, logic eot);
		logic [OFFSET_BITS-1:0] p;
		logic consumed;
		due_token_t d;
		p = char_pos;
		consumed = 1'b0;
		word_tokens.delete();
		if (eot) begin
			flush_run();
			add_token(K_END, p, 0);
			char_pos = '0;
		end else begin
			case (mode)
				LX_IDENT: begin
					if (is_letter(c) || is_digit(c) || c == "_") begin
						if (run_len < 6)
							kw_window[run_len[2:0]] = upcase(c);
						grow_run();
						consumed = 1'b1;
					end else begin
						flush_run();
					end
				end
				LX_NUM: begin
					if (is_digit(c)) begin
						grow_run();
						consumed = 1'b1;
					end else begin
						flush_run();
					end
				end
				LX_STR: begin
					if (c == "'") begin
						add_token(K_STR, run_at, run_len);
						mode = LX_IDLE;
						run_len = '0;
					end else begin
						grow_run();
					end
					consumed = 1'b1;
				end
				LX_GT, LX_LT, LX_BANG: begin
					if (c == "=") begin
						add_token(mode == LX_GT ? K_GE : mode == LX_LT ? K_LE : K_NE, run_at, 2);
						mode = LX_IDLE;
						run_len = '0;
						consumed = 1'b1;
					end else begin
						flush_run();
					end
				end
				default: ;
			endcase
			if (!consumed)
				begin_char(c, p);
			char_pos = p + 1'b1;
		end
		foreach (word_tokens[i]) begin
			d.tok = word_tokens[i];
			d.last = (i == word_tokens.size() - 1);
			due_tokens.push_back(d);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = LX_IDLE;
			foreach (kw_window[i])
				kw_window[i] = '0;
			run_len = '0;
			run_at = '0;
			char_pos = '0;
			due_tokens.delete();
			tokens_due = 0;
			fail_count = 0;
		end else begin
			if (in_valid && !in_stall)
				lex_word(char_code, end_of_text);
			if (out_valid && !out_stall) begin
				if (due_tokens.size() == 0) begin
					fail_count++;
					$display({"%0t: unexpected token, expected none, got kind %0d offset %0d",
						" size %0d last %0d"},
						$time, token_kind, token_offset, token_size, last_of_run);
				end else begin
					exp_tok = due_tokens.pop_front();
					if (token_kind !== exp_tok.tok.kind || token_offset !== exp_tok.tok.offset ||
							token_size !== exp_tok.tok.size || last_of_run !== exp_tok.last) begin
						fail_count++;
						$display({"%0t: token mismatch, expected kind %0d offset %0d size %0d",
							" last %0d, got kind %0d offset %0d size %0d last %0d"},
							$time, exp_tok.tok.kind, exp_tok.tok.offset, exp_tok.tok.size,
							exp_tok.last, token_kind, token_offset, token_size, last_of_run);
					end
				end
			end
			tokens_due = due_tokens.size();
		end
	end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
module tb;
	import slx_pkg::*;

	localparam int WATCH_LIMIT = 1000;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [7:0]             char_code;
	logic                   end_of_text;
	logic                   out_valid;
	logic                   out_stall;
	logic [KIND_BITS-1:0]   token_kind;
	logic [OFFSET_BITS-1:0] token_offset;
	logic [LENGTH_BITS-1:0] token_size;
	logic                   last_of_run;

	int          fail_count;
	int          tokens_due;
	int unsigned sent = 0;
	int unsigned idle_run = 0;
	logic        calm = 1'b0;

	string op_text [11] = '{"*", ",", "(", ")", "=", ">", ">=", "<", "<=", "!=", "!"};

	always #4 clk = ~clk;

	sql_token_lexer_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_code    (char_code),
		.end_of_text  (end_of_text),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.token_kind   (token_kind),
		.token_offset (token_offset),
		.token_size   (token_size),
		.last_of_run  (last_of_run)
	);

	lex_token_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_code    (char_code),
		.end_of_text  (end_of_text),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.token_kind   (token_kind),
		.token_offset (token_offset),
		.token_size   (token_size),
		.last_of_run  (last_of_run),
		.fail_count   (fail_count),
		.tokens_due   (tokens_due)
	);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
		if (idle_run >= WATCH_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: hold off a random number of cycles before each token
	initial begin : receiver
		int unsigned hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 9);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	task automatic send_word(logic [7:0] c, logic eot);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_code <= c;
		end_of_text <= eot;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_text(string s);
		foreach (s[i])
			send_word(s[i], 1'b0);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (tokens_due != 0) @(negedge clk);
	endtask

	function automatic logic [7:0] ident_head();
		int unsigned r;
		r = $urandom_range(0, 52);
		if (r < 26)
			return 8'("A" + r);
		if (r < 52)
			return 8'("a" + r - 26);
		return "_";
	endfunction

	function automatic logic [7:0] ident_tail();
		int unsigned r;
		r = $urandom_range(0, 62);
		if (r < 53)
			return ident_head();
		return 8'("0" + r - 53);
	endfunction

	function automatic logic [7:0] blank_char();
		if ($urandom_range(0, 1))
			return " ";
		return 8'($urandom_range(9, 13));
	endfunction

	function automatic logic [7:0] body_char();
		logic [7:0] c;
		c = 8'($urandom);
		return (c == "'") ? 8'("s") : c;
	endfunction

	// mostly well-formed token sequences, with stray bytes and open strings
	task automatic send_statement();
		int unsigned pick;
		int unsigned k;
		logic [7:0] ch;
		repeat ($urandom_range(0, 10)) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				k = $urandom_range(0, KW_COUNT - 1);
				for (int i = 0; i < KW_LEN[k]; i++) begin
					ch = KW_TEXT[k][47 - 8 * i -: 8];
					if ($urandom_range(0, 1))
						ch = ch + 8'd32;
					send_word(ch, 1'b0);
				end
			end else if (pick < 45) begin
				send_word(ident_head(), 1'b0);
				repeat ($urandom_range(0, 7)) send_word(ident_tail(), 1'b0);
			end else if (pick < 55) begin
				repeat ($urandom_range(1, 6)) send_word(8'("0" + $urandom_range(0, 9)), 1'b0);
			end else if (pick < 65) begin
				send_word("'", 1'b0);
				repeat ($urandom_range(0, 6)) send_word(body_char(), 1'b0);
				if ($urandom_range(0, 9) != 0)
					send_word("'", 1'b0);
			end else if (pick < 88) begin
				send_text(op_text[$urandom_range(0, 10)]);
			end else begin
				send_word(8'($urandom), 1'b0);
			end
			if ($urandom_range(0, 9) < 7)
				send_word(blank_char(), 1'b0);
		end
		send_word(8'($urandom), 1'b1);
	endtask

	initial begin : stimulus
		int unsigned mark;
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_code = '0;
		end_of_text = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// operators, lone bang, odd bytes, open string flushed at end of text
		send_text("_z9 >=<=!=!(),*=<>'b'");
		send_word(8'hFF, 1'b0);
		send_word(8'h00, 1'b0);
		send_word("'", 1'b0);
		send_word(8'hA5, 1'b1);
		wait_drained();

		for (int phase = 0; phase < 6; phase++) begin
			calm = (phase == 2 || phase == 4);
			mark = sent;
			while (sent - mark < 300)
				send_statement();
			wait_drained();
		end
		calm = 1'b0;

		repeat (6) @(negedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
